@@ sv/fsp_pkg.sv @@
`timescale 1ns / 1ps
package fsp_pkg;

    localparam logic [31:0] K_INV2PI = 32'h3E22_F983;
    localparam logic [31:0] K_TWOPI  = 32'h40C9_0FDB;
    localparam logic [31:0] K_C3     = 32'hBE2A_AAAB;
    localparam logic [31:0] K_C5     = 32'h3C08_8889;
    localparam logic [31:0] K_C7     = 32'hB950_0D01;
    localparam logic [31:0] K_ONE    = 32'h3F80_0000;
    localparam logic [31:0] K_NEGZ   = 32'h8000_0000;
    localparam logic [31:0] K_DNAN   = 32'h7FC0_0000;

    typedef logic signed [12:0] t_exp;

    typedef enum logic [1:0] {
        FMT_FP32  = 2'd0,
        FMT_FP16  = 2'd1,
        FMT_INT8  = 2'd2,
        FMT_UINT8 = 2'd3
    } t_fmt;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_in;
    } t_fsp_in;

    typedef struct packed {
        logic [31:0] sine_bits;
        logic        format_error;
        logic        last_out;
    } t_fsp_out;

    function automatic logic f_is_nan(input logic [31:0] v);
        return v[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic f_is_inf(input logic [31:0] v);
        return v[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic f_is_zero(input logic [31:0] v);
        return v[30:0] == 31'h0;
    endfunction

    // significand of a finite fp32, value = mant * 2^exp
    function automatic logic [23:0] f_mant32(input logic [31:0] v);
        return (v[30:23] == 8'h0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
    endfunction

    function automatic t_exp f_exp32(input logic [31:0] v);
        return (v[30:23] == 8'h0) ? -13'sd149 : ($signed({5'b0, v[30:23]}) - 13'sd150);
    endfunction

    // leading zero count, 64 when the word is zero
    function automatic logic [6:0] f_lzc64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    // round a normalized significand (bit 63 set) with biased exponent b
    function automatic logic [31:0] f_round_pack(input logic sign, input logic [63:0] m,
                                                 input t_exp b, input logic is16);
        logic [31:0]  sbit;
        logic [31:0]  res;
        logic [4:0]   fb;
        t_exp         emax;
        t_exp         sh_full;
        logic [6:0]   sh;
        logic [127:0] ext;
        logic [24:0]  mant;
        logic         inc;
        fb      = is16 ? 5'd10 : 5'd23;
        emax    = is16 ? 13'sd31 : 13'sd255;
        sbit    = sign ? (is16 ? 32'h0000_8000 : 32'h8000_0000) : 32'h0;
        sh_full = 13'sd63 - $signed({8'b0, fb}) + ((b <= 13'sd0) ? (13'sd1 - b) : 13'sd0);
        sh      = (sh_full > 13'sd127) ? 7'd127 : sh_full[6:0];
        ext     = {m, 64'b0} >> sh;
        mant    = ext[88:64];
        inc     = ext[63] & ((|ext[62:0]) | ext[64]);
        mant    = mant + {24'b0, inc};
        if (b >= emax) begin
            res = sbit | (is16 ? 32'h0000_7C00 : 32'h7F80_0000);
        end else if (b <= 13'sd0) begin
            res = sbit | {7'b0, mant};
        end else begin
            res = sbit | (({19'b0, b - 13'sd1} << fb) + {7'b0, mant});
        end
        return res;
    endfunction

endpackage

@@ sv/fsp_dly.sv @@
`timescale 1ns / 1ps
module fsp_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

@@ sv/fsp_fma.sv @@
`timescale 1ns / 1ps
module fsp_fma (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_y
);
    import fsp_pkg::*;

    // stage A: special operands and significand product
    logic        sp_a;
    logic        spec_a;
    logic [31:0] specv_a;

    always_comb begin
        sp_a    = i_a[31] ^ i_b[31];
        spec_a  = 1'b1;
        specv_a = K_DNAN;
        if (f_is_nan(i_a) || f_is_nan(i_b) || f_is_nan(i_c)) begin
            specv_a = K_DNAN;
        end else if (f_is_inf(i_a) || f_is_inf(i_b)) begin
            if (f_is_zero(i_a) || f_is_zero(i_b)) begin
                specv_a = K_DNAN;
            end else if (f_is_inf(i_c) && (i_c[31] != sp_a)) begin
                specv_a = K_DNAN;
            end else begin
                specv_a = {sp_a, 31'h7F80_0000};
            end
        end else if (f_is_inf(i_c)) begin
            specv_a = i_c;
        end else if (f_is_zero(i_a) || f_is_zero(i_b)) begin
            if (f_is_zero(i_c)) begin
                specv_a = (sp_a == i_c[31]) ? {sp_a, 31'b0} : 32'h0;
            end else begin
                specv_a = i_c;
            end
        end else begin
            spec_a = 1'b0;
        end
    end

    logic        r_a_spec;
    logic [31:0] r_a_specv;
    logic [47:0] r_a_prod;
    t_exp        r_a_pe;
    logic        r_a_sp;
    logic [23:0] r_a_q;
    t_exp        r_a_ce;
    logic        r_a_sc;
    logic        r_a_cz;

    always_ff @(posedge i_clk) begin
        r_a_spec  <= spec_a;
        r_a_specv <= specv_a;
        r_a_prod  <= {24'b0, f_mant32(i_a)} * {24'b0, f_mant32(i_b)};
        r_a_pe    <= f_exp32(i_a) + f_exp32(i_b);
        r_a_sp    <= sp_a;
        r_a_q     <= f_mant32(i_c);
        r_a_ce    <= f_exp32(i_c);
        r_a_sc    <= i_c[31];
        r_a_cz    <= f_is_zero(i_c);
    end

    // stage B: bring both terms to bit 60, order by magnitude
    logic [6:0]  kp_b;
    logic [6:0]  kq_b;
    logic [63:0] p_b;
    logic [63:0] q_b;
    t_exp        pe_b;
    t_exp        ce_b;
    logic        pfirst_b;

    always_comb begin
        kp_b     = f_lzc64({16'b0, r_a_prod}) - 7'd3;
        kq_b     = f_lzc64({40'b0, r_a_q}) - 7'd3;
        p_b      = {16'b0, r_a_prod} << kp_b;
        q_b      = {40'b0, r_a_q} << kq_b;
        pe_b     = r_a_pe - $signed({6'b0, kp_b});
        ce_b     = r_a_ce - $signed({6'b0, kq_b});
        pfirst_b = r_a_cz || (pe_b > ce_b) || ((pe_b == ce_b) && (p_b >= q_b));
    end

    logic        r_b_spec;
    logic [31:0] r_b_specv;
    logic [63:0] r_b_x;
    logic [63:0] r_b_y;
    t_exp        r_b_xe;
    t_exp        r_b_d;
    logic        r_b_xs;
    logic        r_b_sub;
    logic        r_b_cz;

    always_ff @(posedge i_clk) begin
        r_b_spec  <= r_a_spec;
        r_b_specv <= r_a_specv;
        r_b_x     <= pfirst_b ? p_b : q_b;
        r_b_y     <= pfirst_b ? q_b : p_b;
        r_b_xe    <= pfirst_b ? pe_b : ce_b;
        r_b_d     <= pfirst_b ? (pe_b - ce_b) : (ce_b - pe_b);
        r_b_xs    <= pfirst_b ? r_a_sp : r_a_sc;
        r_b_sub   <= r_a_sp != r_a_sc;
        r_b_cz    <= r_a_cz;
    end

    // stage C: align the smaller term with a sticky bit, add or subtract
    logic [63:0] y_c;
    logic [63:0] mask_c;

    always_comb begin
        mask_c = (64'h1 << r_b_d[5:0]) - 64'h1;
        if (r_b_cz) begin
            y_c = 64'h0;
        end else if (r_b_d >= 13'sd64) begin
            y_c = 64'h1;
        end else if (r_b_d > 13'sd0) begin
            y_c = (r_b_y >> r_b_d[5:0]) | {63'b0, |(r_b_y & mask_c)};
        end else begin
            y_c = r_b_y;
        end
    end

    logic        r_c_spec;
    logic [31:0] r_c_specv;
    logic [63:0] r_c_s;
    t_exp        r_c_xe;
    logic        r_c_xs;

    always_ff @(posedge i_clk) begin
        r_c_spec  <= r_b_spec;
        r_c_specv <= r_b_specv;
        r_c_s     <= (r_b_sub && !r_b_cz) ? (r_b_x - y_c) : (r_b_x + y_c);
        r_c_xe    <= r_b_xe;
        r_c_xs    <= r_b_xs;
    end

    // stage D1: normalize to bit 63; exact cancellation gives +0
    logic [6:0] lz_d;

    assign lz_d = f_lzc64(r_c_s);

    logic        r_d_spec;
    logic [31:0] r_d_specv;
    logic [63:0] r_d_m;
    t_exp        r_d_b;
    logic        r_d_sign;

    always_ff @(posedge i_clk) begin
        r_d_spec  <= r_c_spec || (r_c_s == 64'h0);
        r_d_specv <= r_c_spec ? r_c_specv : 32'h0;
        r_d_m     <= r_c_s << lz_d[5:0];
        r_d_b     <= r_c_xe - $signed({6'b0, lz_d}) + 13'sd190;
        r_d_sign  <= r_c_xs;
    end

    // stage D2: round and pack
    logic [31:0] r_y;

    always_ff @(posedge i_clk) begin
        r_y <= r_d_spec ? r_d_specv : f_round_pack(r_d_sign, r_d_m, r_d_b, 1'b0);
    end

    assign o_y = r_y;
endmodule

@@ sv/float_sine_polynomial_core.sv @@
`timescale 1ns / 1ps
// The result strobe o_done and the result are presented in the same cycle.
// Throughput: one transaction per cycle; busy is held low, nothing stalls.
// The depth is set by seven five-stage fused multiply-add units in a chain,
// plus input, widen, round-to-integer and two narrowing stages.
// Reset (synchronous, active low) clears the valid pipeline and selects fp32.
module float_sine_polynomial_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fsp_pkg::t_fsp_in   i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    output logic               o_done,
    output fsp_pkg::t_fsp_out  o_result
);
    import fsp_pkg::*;

    localparam int FMA_LAT  = 5;
    localparam int PIPE_LAT = 4 + 7 * FMA_LAT;
    localparam int SIDE_LAT = 1 + 7 * FMA_LAT;

    typedef struct packed {
        t_fmt        fmt;
        logic        last;
        logic        byp;
        logic [31:0] bypv;
    } t_side;

    function automatic logic [31:0] f_widen16(input logic [15:0] h);
        logic [31:0] res;
        logic [6:0]  lz;
        logic [23:0] t;
        logic [7:0]  ex;
        lz = f_lzc64({54'b0, h[9:0]});
        t  = {14'b0, h[9:0]} << (lz - 7'd40);
        ex = 8'(9'd166 - {2'b0, lz});
        if (h[14:10] == 5'h1F) begin
            res = (h[9:0] != 10'h0) ? ({h[15], 31'b0} | K_DNAN | {9'b0, h[9:0], 13'b0})
                                    : {h[15], 31'h7F80_0000};
        end else if (h[14:10] == 5'h0) begin
            res = (h[9:0] == 10'h0) ? {h[15], 31'b0} : {h[15], ex, t[22:0]};
        end else begin
            res = {h[15], {3'b0, h[14:10]} + 8'd112, h[9:0], 13'b0};
        end
        return res;
    endfunction

    // round to an integral value, ties to even
    function automatic logic [31:0] f_rint32(input logic [31:0] v);
        logic [31:0] res;
        logic [31:0] mask;
        logic [31:0] frac;
        logic [31:0] half;
        logic [31:0] whole;
        logic [4:0]  f;
        f     = 5'(8'd150 - v[30:23]);
        mask  = (32'h1 << f) - 32'h1;
        frac  = v & mask;
        half  = 32'h1 << (f - 5'd1);
        whole = v & ~mask;
        if (v[30:23] >= 8'd150) begin
            res = v;
        end else if (v[30:23] < 8'd126) begin
            res = {v[31], 31'b0};
        end else if (v[30:23] == 8'd126) begin
            res = (v[30:0] == 31'h3F00_0000) ? {v[31], 31'b0} : ({v[31], 31'b0} | K_ONE);
        end else begin
            if ((frac > half) || ((frac == half) && whole[f])) begin
                whole = whole + (32'h1 << f);
            end
            res = whole;
        end
        return res;
    endfunction

    // configuration and valid pipeline
    t_fmt                r_fmt;
    logic [PIPE_LAT:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_FP32;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= t_fmt'(i_cfg_wdata);
            end
            r_vld <= {r_vld[PIPE_LAT-1:0], start & ~busy};
        end
    end

    assign busy = 1'b0;

    // input register
    logic [31:0] r_in_v;
    logic        r_in_last;
    t_fmt        r_in_fmt;

    always_ff @(posedge i_clk) begin
        r_in_v    <= i_item.value_bits;
        r_in_last <= i_item.last_in;
        r_in_fmt  <= r_fmt;
    end

    // widen and catch NaN / infinity ahead of the arithmetic
    logic [31:0] x_w;
    t_side       side_w;

    always_comb begin
        x_w         = (r_in_fmt == FMT_FP16) ? f_widen16(r_in_v[15:0]) : r_in_v;
        side_w.fmt  = r_in_fmt;
        side_w.last = r_in_last;
        side_w.byp  = f_is_nan(x_w) || f_is_inf(x_w);
        side_w.bypv = f_is_nan(x_w) ? (x_w | 32'h0040_0000) : K_DNAN;
    end

    logic [31:0] r_x;
    t_side       r_side;

    always_ff @(posedge i_clk) begin
        r_x    <= x_w;
        r_side <= side_w;
    end

    // range reduction
    logic [31:0] t_q;
    logic [31:0] x_d;
    logic [31:0] r_n;
    logic [31:0] r_q;

    fsp_fma u_fma_scale (.i_clk(i_clk), .i_a(r_x), .i_b(K_INV2PI), .i_c(K_NEGZ), .o_y(t_q));

    always_ff @(posedge i_clk) begin
        r_n <= f_rint32(t_q);
    end

    fsp_dly #(.WIDTH(32), .DEPTH(FMA_LAT + 1)) u_dly_x (.i_clk(i_clk), .i_d(r_x), .o_q(x_d));

    fsp_fma u_fma_reduce (
        .i_clk(i_clk), .i_a({~r_n[31], r_n[30:0]}), .i_b(K_TWOPI), .i_c(x_d), .o_y(r_q)
    );

    // polynomial in r squared
    logic [31:0] r2_q;
    logic [31:0] r2_d1;
    logic [31:0] r2_d2;
    logic [31:0] r_d;
    logic [31:0] p7_q;
    logic [31:0] p5_q;
    logic [31:0] p3_q;
    logic [31:0] y_q;

    fsp_fma u_fma_sq (.i_clk(i_clk), .i_a(r_q), .i_b(r_q), .i_c(K_NEGZ), .o_y(r2_q));

    fsp_dly #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_r2a (.i_clk(i_clk), .i_d(r2_q), .o_q(r2_d1));
    fsp_dly #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_r2b (.i_clk(i_clk), .i_d(r2_d1), .o_q(r2_d2));
    fsp_dly #(.WIDTH(32), .DEPTH(4 * FMA_LAT)) u_dly_r (.i_clk(i_clk), .i_d(r_q), .o_q(r_d));

    fsp_fma u_fma_c7 (.i_clk(i_clk), .i_a(K_C7), .i_b(r2_q), .i_c(K_C5), .o_y(p7_q));
    fsp_fma u_fma_c5 (.i_clk(i_clk), .i_a(p7_q), .i_b(r2_d1), .i_c(K_C3), .o_y(p5_q));
    fsp_fma u_fma_c3 (.i_clk(i_clk), .i_a(p5_q), .i_b(r2_d2), .i_c(K_ONE), .o_y(p3_q));
    fsp_fma u_fma_out (.i_clk(i_clk), .i_a(p3_q), .i_b(r_d), .i_c(K_NEGZ), .o_y(y_q));

    t_side side_d;

    fsp_dly #(.WIDTH($bits(t_side)), .DEPTH(SIDE_LAT)) u_dly_side (
        .i_clk(i_clk), .i_d(r_side), .o_q(side_d)
    );

    // narrow stage 1: pick the fp32 result, classify and normalize for fp16
    logic [31:0] y32_n;
    logic [6:0]  lz_n;
    logic        sp16_n;
    logic [15:0] v16_n;

    always_comb begin
        y32_n  = side_d.byp ? side_d.bypv : y_q;
        lz_n   = f_lzc64({40'b0, f_mant32(y32_n)});
        sp16_n = 1'b1;
        if (f_is_nan(y32_n)) begin
            v16_n = {y32_n[31], 5'h1F, 1'b1, y32_n[21:13]};
        end else if (f_is_inf(y32_n)) begin
            v16_n = {y32_n[31], 15'h7C00};
        end else if (f_is_zero(y32_n)) begin
            v16_n = {y32_n[31], 15'h0};
        end else begin
            v16_n  = 16'h0;
            sp16_n = 1'b0;
        end
    end

    logic [31:0] r_n1_y32;
    logic        r_n1_sp16;
    logic [15:0] r_n1_v16;
    logic [63:0] r_n1_m;
    t_exp        r_n1_b;
    t_fmt        r_n1_fmt;
    logic        r_n1_last;

    always_ff @(posedge i_clk) begin
        r_n1_y32  <= y32_n;
        r_n1_sp16 <= sp16_n;
        r_n1_v16  <= v16_n;
        r_n1_m    <= {40'b0, f_mant32(y32_n)} << lz_n[5:0];
        r_n1_b    <= f_exp32(y32_n) - $signed({6'b0, lz_n}) + 13'sd78;
        r_n1_fmt  <= side_d.fmt;
        r_n1_last <= side_d.last;
    end

    // narrow stage 2: round to fp16 and build the result transaction
    logic [31:0] h_rnd;
    t_fsp_out    out_n;

    always_comb begin
        h_rnd              = f_round_pack(r_n1_y32[31], r_n1_m, r_n1_b, 1'b1);
        out_n.last_out     = r_n1_last;
        out_n.format_error = 1'b0;
        case (r_n1_fmt)
            FMT_FP32: begin
                out_n.sine_bits = r_n1_y32;
            end
            FMT_FP16: begin
                out_n.sine_bits = {16'b0, r_n1_sp16 ? r_n1_v16 : h_rnd[15:0]};
            end
            default: begin
                out_n.sine_bits    = 32'h0;
                out_n.format_error = 1'b1;
            end
        endcase
    end

    t_fsp_out r_out;
    t_fmt     r_out_fmt;

    always_ff @(posedge i_clk) begin
        r_out     <= out_n;
        r_out_fmt <= r_n1_fmt;
    end

    assign o_done   = r_vld[PIPE_LAT];
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(PIPE_LAT + 1) o_done)
        else $error("accepted transaction did not complete on schedule");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, PIPE_LAT + 1))
        else $error("result strobe without a matching transaction");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.format_error) |-> (o_result.sine_bits == 32'h0))
        else $error("format error result is not zero");

    a_fp16_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_out_fmt == FMT_FP16)) |-> (o_result.sine_bits[31:16] == 16'h0))
        else $error("fp16 result has upper bits set");
endmodule

@@ test/float_sine_polynomial_core_test.sv @@
`timescale 1ns / 1ps
module float_sine_polynomial_core_test;
    import fsp_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_fsp_in  i_item;
    logic     i_cfg_we;
    logic [1:0] i_cfg_wdata;
    logic     o_done;
    t_fsp_out o_result;

    t_fmt     fmt_reg;
    t_fsp_out sine_expected_q[$];
    int       mismatch_count;
    int       idle_pct;

    float_sine_polynomial_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- sine predictor ----------------

    function automatic logic [31:0] pack_rounded(input logic sgn, input longint unsigned m,
                                                 input int e, input int fb, input int bias,
                                                 input int emax, input logic [31:0] sbit);
        logic [31:0] s;
        longint unsigned mant, rem, half;
        int b, sh;
        s = sgn ? sbit : 32'h0;
        while (m[63] == 1'b0) begin
            m = m << 1;
            e--;
        end
        b = 63 + e + bias;
        if (b >= emax) return s | (32'(emax) << fb);
        sh = 63 - fb + ((b <= 0) ? (1 - b) : 0);
        if (sh >= 65) return s;
        if (sh == 64) begin
            mant = 0;
            rem  = m;
            half = 64'h8000_0000_0000_0000;
        end else begin
            mant = m >> sh;
            rem  = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
        end
        if (rem > half || (rem == half && mant[0])) mant++;
        if (b <= 0) return s | mant[31:0];
        return s | ((32'(b - 1) << fb) + mant[31:0]);
    endfunction

    function automatic longint unsigned sig32(input logic [31:0] v, output int e);
        if (v[30:23] == 8'h0) begin
            e = -149;
            return {41'b0, v[22:0]};
        end
        e = int'(v[30:23]) - 150;
        return {40'b0, 1'b1, v[22:0]};
    endfunction

    function automatic logic nan32(input logic [31:0] v);
        return v[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic inf32(input logic [31:0] v);
        return v[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic zero32(input logic [31:0] v);
        return v[30:0] == 31'h0;
    endfunction

    function automatic logic [31:0] fused_mul_add(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] c);
        logic sp, sc, xs, ys;
        longint unsigned p, q, x, y, s;
        int ea, eb, pe, ce, xe, ye, d;
        sp = a[31] ^ b[31];
        sc = c[31];
        if (nan32(a) || nan32(b) || nan32(c)) return K_DNAN;
        if (inf32(a) || inf32(b)) begin
            if (zero32(a) || zero32(b)) return K_DNAN;
            if (inf32(c) && sc != sp) return K_DNAN;
            return {sp, 31'h7F80_0000};
        end
        if (inf32(c)) return c;
        if (zero32(a) || zero32(b)) begin
            if (zero32(c)) return (sp == sc) ? {sp, 31'h0} : 32'h0;
            return c;
        end
        p  = sig32(a, ea) * sig32(b, eb);
        pe = ea + eb;
        if (zero32(c)) return pack_rounded(sp, p, pe, 23, 127, 255, 32'h8000_0000);
        q = sig32(c, ce);
        while (p[63:60] == 4'h0) begin
            p = p << 1;
            pe--;
        end
        while (q[63:60] == 4'h0) begin
            q = q << 1;
            ce--;
        end
        if (pe > ce || (pe == ce && p >= q)) begin
            x = p; xe = pe; xs = sp; y = q; ye = ce; ys = sc;
        end else begin
            x = q; xe = ce; xs = sc; y = p; ye = pe; ys = sp;
        end
        d = xe - ye;
        if (d >= 64) y = 1;
        else if (d > 0) y = (y >> d) | longint'((y & ((64'd1 << d) - 64'd1)) != 0);
        s = (xs == ys) ? x + y : x - y;
        if (s == 0) return 32'h0;
        return pack_rounded(xs, s, xe, 23, 127, 255, 32'h8000_0000);
    endfunction

    function automatic logic [31:0] round_integral(input logic [31:0] v);
        int unsigned ex, f;
        logic [31:0] mask, frac, half, whole;
        ex = 32'(v[30:23]);
        if (ex >= 150) return v;
        if (ex < 126) return {v[31], 31'h0};
        if (ex == 126) return (v[30:0] == 31'h3F00_0000) ? {v[31], 31'h0} : {v[31], K_ONE[30:0]};
        f     = 150 - ex;
        mask  = (32'd1 << f) - 32'd1;
        frac  = v & mask;
        half  = 32'd1 << (f - 1);
        whole = v & ~mask;
        if (frac > half || (frac == half && whole[f])) whole = whole + (32'd1 << f);
        return whole;
    endfunction

    function automatic logic [31:0] sine_fp32(input logic [31:0] x);
        logic [31:0] n, r, r2, p;
        if (nan32(x)) return x | 32'h0040_0000;
        if (inf32(x)) return K_DNAN;
        n  = round_integral(fused_mul_add(x, K_INV2PI, K_NEGZ));
        r  = fused_mul_add(n ^ 32'h8000_0000, K_TWOPI, x);
        r2 = fused_mul_add(r, r, K_NEGZ);
        p  = fused_mul_add(K_C7, r2, K_C5);
        p  = fused_mul_add(p, r2, K_C3);
        p  = fused_mul_add(p, r2, K_ONE);
        return fused_mul_add(p, r, K_NEGZ);
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        if (h[14:10] == 5'h1F)
            return (h[9:0] != 0) ? ({h[15], 31'h0} | K_DNAN | {9'b0, h[9:0], 13'b0})
                                 : {h[15], 31'h7F80_0000};
        if (h[14:10] == 5'h0) begin
            if (h[9:0] == 0) return {h[15], 31'h0};
            return pack_rounded(h[15], {54'b0, h[9:0]}, -24, 23, 127, 255, 32'h8000_0000);
        end
        return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'b0};
    endfunction

    function automatic logic [31:0] single_to_half(input logic [31:0] v);
        longint unsigned m;
        int e;
        if (nan32(v)) return {16'b0, v[31], 15'h7E00 | {5'b0, v[22:13]}};
        if (inf32(v)) return {16'b0, v[31], 15'h7C00};
        if (zero32(v)) return {16'b0, v[31], 15'h0};
        m = sig32(v, e);
        return pack_rounded(v[31], m, e, 10, 15, 31, 32'h0000_8000);
    endfunction

    function automatic t_fsp_out predict_sine(input t_fsp_in it, input t_fmt fmt);
        t_fsp_out r;
        r.sine_bits    = 32'h0;
        r.format_error = 1'b0;
        r.last_out     = it.last_in;
        case (fmt)
            FMT_FP32: r.sine_bits = sine_fp32(it.value_bits);
            FMT_FP16: r.sine_bits = single_to_half(sine_fp32(half_to_single(it.value_bits[15:0])));
            default:  r.format_error = 1'b1;
        endcase
        return r;
    endfunction

    // ---------------- driving and checking ----------------

    task automatic send_element(input logic [31:0] v, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = '{value_bits: v, last_in: last};
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sine_expected_q.push_back(predict_sine(i_item, fmt_reg));
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        start = 1'b0;
        while (sine_expected_q.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_format(input t_fmt fmt);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = fmt;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        fmt_reg  = fmt;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sine_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %h %b %b", o_result.sine_bits,
                             o_result.format_error, o_result.last_out);
            end else begin
                t_fsp_out e;
                e = sine_expected_q.pop_front();
                if (o_result.sine_bits !== e.sine_bits
                        || o_result.format_error !== e.format_error
                        || o_result.last_out !== e.last_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %b %b, got %h %b %b",
                                 e.sine_bits, e.format_error, e.last_out, o_result.sine_bits,
                                 o_result.format_error, o_result.last_out);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_fp32_corners();
        logic [31:0] vals[] = '{32'h0, 32'h8000_0000, 32'h1, 32'h807F_FFFF, 32'h0080_0000,
            32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
            32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h4049_0FDB, 32'h40C9_0FDB,
            32'hC0C9_0FDB, 32'h3F00_0000, 32'h4B00_0000, 32'h4F00_0000};
        write_format(FMT_FP32);
        idle_pct = 0;
        foreach (vals[i]) send_element(vals[i], i[0]);
    endtask

    task automatic test_fp16_corners();
        logic [31:0] vals[] = '{32'h0, 32'h8000, 32'h1, 32'h03FF, 32'h0400, 32'h7BFF,
            32'hFBFF, 32'h7C00, 32'hFC00, 32'h7E00, 32'h7C01, 32'hFFFF_FFFF, 32'h3C00,
            32'h4248, 32'hABCD_4648, 32'h5640};
        write_format(FMT_FP16);
        foreach (vals[i]) send_element(vals[i], i[0]);
    endtask

    task automatic test_unsupported_formats();
        write_format(FMT_INT8);
        send_element(32'hFFFF_FFFF, 1'b1);
        send_element(32'h3F80_0000, 1'b0);
        write_format(FMT_UINT8);
        send_element(32'h0, 1'b0);
        send_element(32'h7FC0_0000, 1'b1);
    endtask

    task automatic test_random_stream(input t_fmt fmt, input int count, input int pct);
        logic [31:0] v;
        write_format(fmt);
        idle_pct = pct;
        repeat (count) begin
            v = $urandom;
            // keep most fp32 values where range reduction does real work
            if (fmt == FMT_FP32 && $urandom_range(3) != 0)
                v[30:23] = 8'($urandom_range(100, 160));
            send_element(v, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        start          = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = FMT_FP32;
        fmt_reg        = FMT_FP32;
        mismatch_count = 0;
        idle_pct       = 0;
        i_rst_n        = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fp32_corners();
        test_fp16_corners();
        test_unsupported_formats();
        test_random_stream(FMT_FP32, 400, 0);
        test_random_stream(FMT_FP16, 300, 82);
        test_random_stream(FMT_FP32, 350, 23);
        test_random_stream(FMT_UINT8, 100, 0);
        test_random_stream(FMT_FP16, 300, 0);
        test_random_stream(FMT_INT8, 50, 82);
        test_random_stream(FMT_FP32, 150, 82);
        drain_pipeline();

        if (mismatch_count == 0 && sine_expected_q.size() == 0) begin
            $display("PASS float_sine_polynomial_core");
        end else begin
            $display("FAIL float_sine_polynomial_core");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL float_sine_polynomial_core");
        $finish;
    end

endmodule
